// File: src/sde_pkg.sv
// ----------------------------------------------------------------------------
// sde_pkg: shared types and codes for the sorted deque engine
// Operation codes, status codes and the request and response transaction types.
// ----------------------------------------------------------------------------
package sde_pkg;

   typedef enum logic [2:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_SORT_INS   = 3'd4,
      OP_SORT       = 3'd5,
      OP_REVERSE    = 3'd6,
      OP_NOP        = 3'd7
   } op_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_UNDERFLOW = 2'd1,
      ST_OVERFLOW  = 2'd2,
      ST_RSVD      = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SORT,
      FSM_REV
   } fsm_type;

   // per-cycle command to every cell
   typedef enum logic [2:0] {
      CC_HOLD,
      CC_SHR,     // take left neighbor (push front)
      CC_SHL,     // take right neighbor (pop front)
      CC_LOAD,    // cell at the write index loads the data word
      CC_ODD,     // odd-even transposition, odd pairs
      CC_EVEN,    // odd-even transposition, even pairs
      CC_SWAP     // mirror swap of the reverse sweep
   } cmd_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] value;
   } req_type;

   typedef struct packed {
      logic [31:0] popped_value;
      logic        popped_valid;
      logic [1:0]  status;
      logic [4:0]  entry_count;
      logic        is_empty;
   } rsp_type;

endpackage

// File: src/sde_cell.sv
// ----------------------------------------------------------------------------
// sde_cell: one storage slot of the deque chain
// Holds one word; shifts, loads or compare-swaps with its neighbors on command.
// ----------------------------------------------------------------------------
module sde_cell #(
   parameter int DW  = 32,
   parameter int IDX = 0,
   parameter int AW  = 4
) (
   input  logic              clock,
   input  sde_pkg::cmd_type  cmd,
   input  logic [AW-1:0]     widx,
   input  logic [AW-1:0]     pidx,
   input  logic [DW-1:0]     din,
   input  logic [DW-1:0]     left,
   input  logic [DW-1:0]     right,
   input  logic [DW-1:0]     mirror,
   input  logic              in_use,
   input  logic              right_use,
   output logic [DW-1:0]     word
);
   import sde_pkg::*;

   logic [DW-1:0] word_ff, word_in;
   logic          odd_self;
   logic          is_lower;

   // pair low member: index parity matches the phase
   assign odd_self = IDX[0];

   always_comb begin
      word_in = word_ff;
      is_lower = 1'b0;
      case (cmd)
         CC_SHR:  word_in = (IDX == 0) ? din : left;
         CC_SHL:  word_in = right;
         CC_LOAD: if (widx == AW'(IDX)) word_in = din;
         CC_ODD, CC_EVEN: begin
            is_lower = (odd_self == (cmd == CC_ODD));
            if (is_lower) begin
               if (right_use && in_use && $signed(word_ff) > $signed(right))
                  word_in = right;
            end else if (IDX > 0) begin
               if (in_use && $signed(left) > $signed(word_ff))
                  word_in = left;
            end
         end
         CC_SWAP: if (widx == AW'(IDX) || pidx == AW'(IDX)) word_in = mirror;
         default: word_in = word_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;

endmodule

// File: src/sorted_deque_engine_top.sv
// Push, pop and no-op give their response in the cycle after start is accepted.
// Sort and sorted insert run DEPTH odd-even transposition passes over the
// cell chain, one pass per cycle. Reverse swaps one mirror pair per cycle.
// busy is high while a sweep runs.
// Synchronous reset empties the store; cell contents are not cleared.
// The receiver cannot stall; each response is strobed for one cycle.
// ----------------------------------------------------------------------------
// sorted_deque_engine_top: bounded double-ended queue with sort
// A chain of cells holds the words; a small sequencer drives sweeps.
// ----------------------------------------------------------------------------
module sorted_deque_engine_top #(
   parameter int DEPTH      = 16,
   parameter int DATA_WIDTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  sde_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output sde_pkg::rsp_type  rsp_data
);
   import sde_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int PW = $clog2(DEPTH + 2);

   logic [DATA_WIDTH-1:0] words [DEPTH];
   logic [CW-1:0]   occ_ff, occ_in;
   fsm_type         state_ff, state_in;
   logic [PW-1:0]   pass_ff, pass_in;
   logic [AW-1:0]   lo_ff, lo_in, hi_ff, hi_in;
   logic            strobe_ff, strobe_in;
   rsp_type         rsp_ff, rsp_in;
   cmd_type         cmd;
   logic [AW-1:0]   widx;
   logic [DATA_WIDTH-1:0] din;
   logic            accept;
   op_type          op;
   logic            full;

   assign accept = start && !busy;
   assign op     = op_type'(req_data.kind);
   assign din    = DATA_WIDTH'($signed(req_data.value));
   assign full   = (occ_ff == CW'(DEPTH));

   genvar g;
   generate
      for (g = 0; g < DEPTH; g++) begin : g_cell
         logic [DATA_WIDTH-1:0] lw, rw;
         logic ru;
         if (g == 0) begin : g_l0
            assign lw = words[0];
         end else begin : g_l
            assign lw = words[g-1];
         end
         if (g == DEPTH-1) begin : g_rl
            assign rw = words[g];
            assign ru = 1'b0;
         end else begin : g_r
            assign rw = words[g+1];
            assign ru = (CW'(g + 1) < occ_ff);
         end
         sde_cell #(.DW(DATA_WIDTH), .IDX(g), .AW(AW)) u_cell (
            .clock     (clock),
            .cmd       (cmd),
            .widx      (widx),
            .pidx      (hi_ff),
            .din       (din),
            .left      (lw),
            .right     (rw),
            .mirror    ((AW'(g) == lo_ff) ? words[hi_ff] : words[lo_ff]),
            .in_use    (CW'(g) < occ_ff),
            .right_use (ru),
            .word      (words[g])
         );
      end
   endgenerate

   always_comb begin
      state_in  = state_ff;
      occ_in    = occ_ff;
      pass_in   = pass_ff;
      lo_in     = lo_ff;
      hi_in     = hi_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      cmd       = CC_HOLD;
      widx      = occ_ff[AW-1:0];
      busy      = (state_ff != FSM_IDLE);
      case (state_ff)
         FSM_IDLE: begin
            if (accept) begin
               rsp_in = '0;
               rsp_in.status = ST_OK;
               strobe_in = 1'b1;
               case (op)
                  OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORT_INS: begin
                     if (full) begin
                        rsp_in.status = ST_OVERFLOW;
                     end else begin
                        cmd    = (op == OP_PUSH_FRONT) ? CC_SHR : CC_LOAD;
                        occ_in = occ_ff + CW'(1);
                        if (op == OP_SORT_INS) begin
                           strobe_in = 1'b0;
                           state_in  = FSM_SORT;
                           pass_in   = '0;
                        end
                     end
                  end
                  OP_POP_FRONT, OP_POP_BACK: begin
                     if (occ_ff == '0) begin
                        rsp_in.status = ST_UNDERFLOW;
                     end else begin
                        rsp_in.popped_valid = 1'b1;
                        rsp_in.popped_value = (op == OP_POP_FRONT) ?
                           32'($signed(words[0])) :
                           32'($signed(words[AW'(occ_ff - CW'(1))]));
                        if (op == OP_POP_FRONT) cmd = CC_SHL;
                        occ_in = occ_ff - CW'(1);
                     end
                  end
                  OP_SORT: begin
                     strobe_in = 1'b0;
                     state_in  = FSM_SORT;
                     pass_in   = '0;
                  end
                  OP_REVERSE: begin
                     if (occ_ff > CW'(1)) begin
                        strobe_in = 1'b0;
                        state_in  = FSM_REV;
                        lo_in     = '0;
                        hi_in     = AW'(occ_ff - CW'(1));
                     end
                  end
                  default: ;
               endcase
               rsp_in.entry_count = 5'(occ_in);
               rsp_in.is_empty    = (occ_in == '0);
            end
         end
         FSM_SORT: begin
            cmd     = pass_ff[0] ? CC_ODD : CC_EVEN;
            pass_in = pass_ff + PW'(1);
            if (pass_ff == PW'(DEPTH - 1)) begin
               state_in  = FSM_IDLE;
               strobe_in = 1'b1;
            end
         end
         FSM_REV: begin
            cmd   = CC_SWAP;
            widx  = lo_ff;
            lo_in = lo_ff + AW'(1);
            hi_in = hi_ff - AW'(1);
            if (lo_ff + AW'(1) >= hi_ff - AW'(1) || hi_ff == AW'(1)) begin
               state_in  = FSM_IDLE;
               strobe_in = 1'b1;
            end
         end
         default: state_in = FSM_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= FSM_IDLE;
         occ_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         occ_ff    <= occ_in;
         strobe_ff <= strobe_in;
      end
      pass_ff <= pass_in;
      lo_ff   <= lo_in;
      hi_ff   <= hi_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

   a_occ_range: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= CW'(DEPTH)) else $error("occupancy above depth");
   a_sweep_keeps_occ: assert property (@(posedge clock) disable iff (reset)
      busy && $past(busy) |-> $stable(occ_ff)) else $error("count moved in sweep");
   a_no_strobe_on_idle: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && rsp_strobe |-> $past(accept) || $past(busy))
      else $error("spurious response");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the sorted deque engine
// Drives push, pop, sorted insert, sort and reverse transactions with random
// gaps, predicts each response from a local model of the store and compares.
// ----------------------------------------------------------------------------
module testbench;
   import sde_pkg::*;

   localparam int DEPTH = 16;
   localparam int LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic signed [31:0] store [DEPTH];
   int                 fill;
   rsp_type            expected_q [$];
   int                 errors = 0;
   int                 sent = 0;
   int                 checked = 0;
   int                 cycles = 0;

   sorted_deque_engine_top #(.DEPTH(DEPTH), .DATA_WIDTH(32)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_strobe(rsp_strobe), .rsp_data(rsp_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("%0t timeout", $time);
         $display("FAILURE");
         $finish;
      end
   end

   function automatic void sort_store();
      logic signed [31:0] w;
      int j;
      for (int i = 1; i < fill; i++) begin
         w = store[i];
         j = i;
         while (j > 0 && store[j-1] > w) begin
            store[j] = store[j-1];
            j--;
         end
         store[j] = w;
      end
   endfunction

   function automatic rsp_type predict_deque(op_type op, logic signed [31:0] v);
      rsp_type r;
      logic signed [31:0] t;
      r = '0;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK, OP_SORT_INS: begin
            if (fill >= DEPTH) begin
               r.status = ST_OVERFLOW;
            end else if (op == OP_PUSH_FRONT) begin
               for (int i = fill; i > 0; i--) store[i] = store[i-1];
               store[0] = v;
               fill++;
            end else begin
               store[fill] = v;
               fill++;
               if (op == OP_SORT_INS) sort_store();
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (fill == 0) begin
               r.status = ST_UNDERFLOW;
            end else begin
               r.popped_valid = 1'b1;
               if (op == OP_POP_BACK) begin
                  r.popped_value = store[fill-1];
               end else begin
                  r.popped_value = store[0];
                  for (int i = 0; i < fill - 1; i++) store[i] = store[i+1];
               end
               fill--;
            end
         end
         OP_SORT: sort_store();
         OP_REVERSE: begin
            for (int i = 0; i < fill / 2; i++) begin
               t = store[i];
               store[i] = store[fill-1-i];
               store[fill-1-i] = t;
            end
         end
         default: ;
      endcase
      r.entry_count = fill[4:0];
      r.is_empty = (fill == 0);
      return r;
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_q.size() == 0) begin
            $display("%0t unexpected response: actual %h", $time, rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_q.pop_front();
            checked++;
            if (e != rsp_data) begin
               $display("%0t mismatch: expected %h actual %h", $time, e, rsp_data);
               errors++;
            end
         end
      end
   end

   task automatic idle_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
      if (n > 0) begin
         start <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_op(op_type op, logic [31:0] v, bit gaps);
      start <= 1'b1;
      req_data <= '{kind: op, value: v};
      @(posedge clock);
      while (busy) @(posedge clock);
      expected_q.push_back(predict_deque(op, v));
      sent++;
      if (gaps && $urandom_range(0, 2) == 0) begin
         idle_gap();
      end
   endtask

   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_op(OP_POP_FRONT, 32'h0, 0);
      send_op(OP_POP_BACK, 32'h0, 0);
      send_op(OP_SORT, 32'h0, 0);
      send_op(OP_REVERSE, 32'h0, 0);
      send_op(OP_NOP, 32'hFFFFFFFF, 0);
      send_op(OP_SORT_INS, 32'h7FFFFFFF, 0);
      send_op(OP_REVERSE, 32'h0, 0);
      send_op(OP_PUSH_BACK, 32'h80000000, 0);
      send_op(OP_PUSH_FRONT, 32'hFFFFFFFF, 0);
      send_op(OP_SORT_INS, 32'h0, 0);
      send_op(OP_SORT, 32'h0, 0);
      send_op(OP_REVERSE, 32'h0, 0);
      for (int i = 0; i < 12; i++) send_op(OP_PUSH_FRONT, $urandom, 0);
      send_op(OP_SORT_INS, 32'h5, 0);
      send_op(OP_PUSH_BACK, 32'h5, 0);
      drain();
      while (fill > 0) send_op(OP_POP_FRONT, 32'h0, 0);
      drain();
   endtask

   task automatic test_random();
      op_type op;
      logic [31:0] v;
      for (int n = 0; n < 1300; n++) begin
         case ($urandom_range(0, 3))
            0: v = $urandom;
            1: v = $urandom_range(0, 15) - 8;
            2: v = {$urandom_range(0, 1) ? 2'b10 : 2'b01, 30'($urandom)};
            default: v = {1'b0, 31'h7FFFFFF0} + $urandom_range(0, 15);
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2, 3: op = OP_PUSH_FRONT;
            4, 5, 6, 7: op = OP_PUSH_BACK;
            8, 9, 10: op = OP_POP_FRONT;
            11, 12, 13: op = OP_POP_BACK;
            14, 15: op = OP_SORT_INS;
            16: op = OP_SORT;
            17, 18: op = OP_REVERSE;
            default: op = OP_NOP;
         endcase
         send_op(op, v, 1);
         if (n % 400 == 399) drain();
      end
      drain();
   endtask

   initial begin
      fill = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      repeat (40) @(posedge clock);
      $display("Covered %0d transactions, %0d responses checked, all operations", sent, checked);
      $display("including overflow, underflow, sort and reverse on empty to full store.");
      if (errors == 0 && expected_q.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end
endmodule
